// ===== hdl/range_max_point_update_defines.svh =====
// ----------------------------------------------------------------------------
// range_max_point_update_defines
// assertion macros shared by the range maximum store
// ----------------------------------------------------------------------------
// each check is sampled on i_clk and held off while i_rst_n is low
`ifndef RANGE_MAX_POINT_UPDATE_DEFINES_SVH
`define RANGE_MAX_POINT_UPDATE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RMPU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RMPU_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond |=> prop) \
        else $error(msg);
`else
`define RMPU_ASSERT(name, prop, msg)
`define RMPU_ASSERT_NEXT(name, cond, prop, msg)
`endif

`endif

// ===== hdl/rmpu_pkg.sv =====
// ----------------------------------------------------------------------------
// rmpu_pkg
// shared constants, request type and node address map of the max tree
// ----------------------------------------------------------------------------
package rmpu_pkg;

    localparam int LEAF_COUNT  = 1024;
    localparam int FANOUT      = 4;
    localparam int LEVEL_COUNT = 6;
    localparam int NODE_COUNT  = 1365;
    localparam int ADDR_W      = 11;
    localparam int IDX_W       = 11;
    localparam int LVL_W       = 3;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_QUERY,
        KIND_EMPTY,
        KIND_WRITE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
        logic [DATA_W-1:0]  value;
    } t_req;

    // first address of each tree level, leaves at the bottom
    function automatic logic [ADDR_W-1:0] level_base(input logic [LVL_W-1:0] lv);
        logic [ADDR_W-1:0] base;
        case (lv)
            3'd0:    base = 11'd0;
            3'd1:    base = 11'd1024;
            3'd2:    base = 11'd1280;
            3'd3:    base = 11'd1344;
            3'd4:    base = 11'd1360;
            3'd5:    base = 11'd1364;
            default: base = 11'd0;
        endcase
        return base;
    endfunction

endpackage

// ===== hdl/rmpu_ram.sv =====
// ----------------------------------------------------------------------------
// rmpu_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rmpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/rmpu_front.sv =====
// ----------------------------------------------------------------------------
// rmpu_front
// takes requests, sorts them into write, query and empty query, queues them
// ----------------------------------------------------------------------------
`include "range_max_point_update_defines.svh"

module rmpu_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_op,
    input  logic [9:0]                   i_first_index,
    input  logic [10:0]                  i_end_index,
    input  logic [rmpu_pkg::DATA_W-1:0]  i_new_value,
    output logic                         o_req_valid,
    output rmpu_pkg::t_req               o_req,
    input  logic                         i_pop
);
    import rmpu_pkg::*;

    t_req             r_slot [QUEUE_DEPTH];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;
    t_req             req;
    logic             keep;
    logic             push;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] hi;

    assign first = {1'b0, i_first_index};
    assign hi    = (i_end_index > IDX_W'(LEAF_COUNT)) ? IDX_W'(LEAF_COUNT) : i_end_index;

    always_comb begin
        req.lo    = first;
        req.hi    = hi;
        req.value = i_new_value;
        keep      = 1'b1;
        if (i_op) begin
            req.kind = KIND_WRITE;
            keep     = (first < IDX_W'(LEAF_COUNT));
        end else if (first >= hi) begin
            req.kind = KIND_EMPTY;
        end else begin
            req.kind = KIND_QUERY;
        end
    end

    assign o_busy      = (r_count == 2'(QUEUE_DEPTH));
    assign push        = i_start && !o_busy && keep;
    assign o_req_valid = (r_count != 2'd0);
    assign o_req       = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push  ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (push) begin
            r_slot[r_wr_ptr] <= req;
        end
    end

    `RMPU_ASSERT(a_count_bound, r_count <= 2'(QUEUE_DEPTH), "queue count overflow")
    `RMPU_ASSERT(a_pop_nonempty, i_pop |-> (r_count != 2'd0), "pop from empty queue")

endmodule

// ===== hdl/rmpu_back.sv =====
// ----------------------------------------------------------------------------
// rmpu_back
// clears the node ram, then runs writes and queries one at a time
// ----------------------------------------------------------------------------
`include "range_max_point_update_defines.svh"

module rmpu_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  rmpu_pkg::t_req               i_req,
    output logic                         o_pop,
    output logic                         o_max_valid,
    output logic [rmpu_pkg::DATA_W-1:0]  o_max_value
);
    import rmpu_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_Q_RUN,
        ST_Q_DRAIN,
        ST_W_READ,
        ST_W_FOLD
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [IDX_W-1:0]  r_lo, n_lo;
    logic [IDX_W-1:0]  r_hi, n_hi;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [LVL_W-1:0]  r_lv, n_lv;
    logic [1:0]        r_c, n_c;
    logic [DATA_W-1:0] r_m, n_m;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic              r_rd_pend, n_rd_pend;
    logic              r_rd_self, n_rd_self;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] rd_val;
    logic [DATA_W-1:0] fold;

    rmpu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // the node on the write path is taken from the register, not the ram
    assign rd_val = r_rd_self ? r_m : ram_rdata;
    assign fold   = (r_rd_pend && ($signed(rd_val) > $signed(r_acc))) ? rd_val : r_acc;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pos       = r_pos;
        n_lv        = r_lv;
        n_c         = r_c;
        n_m         = r_m;
        n_acc       = fold;
        n_rd_pend   = 1'b0;
        n_rd_self   = 1'b0;
        n_out_valid = 1'b0;
        n_out_value = r_out_value;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = MOST_NEG;
        ram_raddr   = '0;
        o_pop       = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == ADDR_W'(NODE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_pop = 1'b1;
                    case (i_req.kind)
                        KIND_QUERY: begin
                            n_lo    = i_req.lo;
                            n_hi    = i_req.hi;
                            n_lv    = '0;
                            n_acc   = MOST_NEG;
                            n_state = ST_Q_RUN;
                        end
                        KIND_WRITE: begin
                            ram_we    = 1'b1;
                            ram_waddr = i_req.lo;
                            ram_wdata = i_req.value;
                            n_m       = i_req.value;
                            n_pos     = i_req.lo;
                            n_lv      = '0;
                            n_c       = '0;
                            n_acc     = MOST_NEG;
                            n_state   = ST_W_READ;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_value = MOST_NEG;
                        end
                    endcase
                end
            end
            ST_Q_RUN: begin
                if (r_lo < r_hi && r_lo[1:0] != 2'd0) begin
                    ram_raddr = level_base(r_lv) + r_lo;
                    n_rd_pend = 1'b1;
                    n_lo      = r_lo + 1'b1;
                end else if (r_lo < r_hi && r_hi[1:0] != 2'd0) begin
                    ram_raddr = level_base(r_lv) + r_hi - 1'b1;
                    n_rd_pend = 1'b1;
                    n_hi      = r_hi - 1'b1;
                end else if (r_lo < r_hi) begin
                    n_lo = r_lo >> 2;
                    n_hi = r_hi >> 2;
                    n_lv = r_lv + 1'b1;
                end else begin
                    n_state = ST_Q_DRAIN;
                end
            end
            ST_Q_DRAIN: begin
                n_out_valid = 1'b1;
                n_out_value = fold;
                n_state     = ST_IDLE;
            end
            ST_W_READ: begin
                if (r_lv == LVL_W'(LEVEL_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    ram_raddr = level_base(r_lv) + {r_pos[IDX_W-1:2], r_c};
                    n_rd_pend = 1'b1;
                    n_rd_self = (r_c == r_pos[1:0]);
                    n_c       = r_c + 1'b1;
                    if (r_c == 2'd3) begin
                        n_state = ST_W_FOLD;
                    end
                end
            end
            ST_W_FOLD: begin
                ram_we    = 1'b1;
                ram_waddr = level_base(r_lv + 1'b1) + (r_pos >> 2);
                ram_wdata = fold;
                n_m       = fold;
                n_pos     = r_pos >> 2;
                n_lv      = r_lv + 1'b1;
                n_acc     = MOST_NEG;
                n_c       = '0;
                n_state   = ST_W_READ;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_self   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_rd_pend   <= n_rd_pend;
            r_rd_self   <= n_rd_self;
            r_out_valid <= n_out_valid;
        end
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_pos       <= n_pos;
        r_lv        <= n_lv;
        r_c         <= n_c;
        r_m         <= n_m;
        r_acc       <= n_acc;
        r_out_value <= n_out_value;
    end

    assign o_max_valid = r_out_valid;
    assign o_max_value = r_out_value;

    `RMPU_ASSERT(a_pop_idle, o_pop |-> (r_state == ST_IDLE), "pop outside idle")
    `RMPU_ASSERT_NEXT(a_drain_out, r_state == ST_Q_DRAIN, r_out_valid, "query drained without result")
    `RMPU_ASSERT(a_clear_writes, (r_state == ST_CLEAR) |-> ram_we, "clear pass skipped a write")

endmodule

// ===== hdl/range_max_point_update.sv =====
// ----------------------------------------------------------------------------
// range_max_point_update
// point write, range maximum store over 1024 signed words in a 4-way max tree
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// request   in         start high, busy low  i_op, i_first_index, i_end_index, i_new_value
// result    out        o_max_valid strobe    o_max_value
//
// steps: a write holds the back end for the pop with the leaf write, 4 reads and a parent
// write per level, then a step to reach idle; a query holds it for the pop, a read per node
// (26 at most), a step per level climbed, a step to end the walk and a drain step; empty: pop only
// reset: a clearing pass over all 1365 nodes fills the node ram; requests queue but wait for it
// stalls: busy rises only when the two-entry request queue is full; results cannot be
// held off, each is shown for exactly one cycle
//
module range_max_point_update (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic [9:0]                   i_first_index,
    input  logic [10:0]                  i_end_index,
    input  logic [rmpu_pkg::DATA_W-1:0]  i_new_value,
    output logic                         o_max_valid,
    output logic [rmpu_pkg::DATA_W-1:0]  o_max_value
);
    import rmpu_pkg::*;

    // queued request between the front and the back
    t_req req;
    logic req_valid;
    logic req_pop;

    // front: classify (out of range writes dropped, query end clamped) and queue
    rmpu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_op          (i_op),
        .i_first_index (i_first_index),
        .i_end_index   (i_end_index),
        .i_new_value   (i_new_value),
        .o_req_valid   (req_valid),
        .o_req         (req),
        .i_pop         (req_pop)
    );

    // back: tree walk over the node ram
    rmpu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_pop       (req_pop),
        .o_max_valid (o_max_valid),
        .o_max_value (o_max_value)
    );

endmodule

// ===== tb/tb_range_max_point_update.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_max_point_update
// self-checking bench for the point write, range maximum store
// requests are driven in random bursts; a flat array model of the store gives
// the expected maximum of every query, checked in order against the result strobe
// ----------------------------------------------------------------------------
module tb_range_max_point_update;

    import rmpu_pkg::*;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam int   N_RANDOM = 1600;

    // scoreboard: a flat copy of the stored words and the pending query answers
    class range_max_board;
        logic signed [31:0] store_words [LEAF_COUNT];
        logic signed [31:0] pending_max [$];
        int                 mismatches;
        int                 unexpected;

        function void clear_store();
            foreach (store_words[k]) store_words[k] = MOST_NEG;
            pending_max.delete();
            mismatches = 0;
            unexpected = 0;
        endfunction

        // note one accepted request and predict its answer, if any
        function void note_request(logic op, logic [9:0] first_idx, logic [10:0] end_idx,
                                   logic signed [31:0] value);
            int                 top;
            logic signed [31:0] best;
            best = MOST_NEG;
            if (op == OP_WRITE) begin
                store_words[first_idx] = value;
            end else begin
                // end past the store is clamped; empty range gives the most negative value
                top = (end_idx > LEAF_COUNT) ? LEAF_COUNT : end_idx;
                for (int k = first_idx; k < top; k++)
                    if (store_words[k] > best) best = store_words[k];
                pending_max.push_back(best);
            end
        endfunction

        function void check_result(logic [31:0] actual);
            logic signed [31:0] want;
            if (pending_max.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result %h", actual);
            end else begin
                want = pending_max.pop_front();
                if (want !== actual) begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("max_value mismatch: expected %h actual %h", want, actual);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_op;
    logic [9:0]  i_first_index;
    logic [10:0] i_end_index;
    logic [31:0] i_new_value;
    logic        o_max_valid;
    logic [31:0] o_max_value;

    range_max_board board;

    range_max_point_update dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_first_index (i_first_index),
        .i_end_index   (i_end_index),
        .i_new_value   (i_new_value),
        .o_max_valid   (o_max_valid),
        .o_max_value   (o_max_value)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result side: sampled at the rising edge, strobe cannot be held off
    always @(posedge i_clk) begin
        if (i_rst_n && o_max_valid) board.check_result(o_max_value);
    end

    // present one request from the falling edge and hold it until accepted
    task automatic send_request(logic op, logic [9:0] first_idx, logic [10:0] end_idx,
                                logic [31:0] value);
        start         <= 1'b1;
        i_op          <= op;
        i_first_index <= first_idx;
        i_end_index   <= end_idx;
        i_new_value   <= value;
        do @(posedge i_clk); while (busy);
        board.note_request(op, first_idx, end_idx, value);
        @(negedge i_clk);
    endtask

    task automatic drop_start();
        start <= 1'b0;
        @(negedge i_clk);
    endtask

    // interesting values: extremes and random
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // indices bunched just above a random base so ranges are often small
    task automatic random_request(int hot_lo);
        logic [9:0]  a;
        logic [10:0] b;
        int          pick;
        pick = $urandom_range(0, 9);
        a = (pick < 7) ? 10'(hot_lo + $urandom_range(0, 63)) : 10'($urandom);
        case ($urandom_range(0, 7))
            0:       b = 11'($urandom_range(0, 2047));     // often past the store
            1:       b = 11'(a);                           // empty
            2:       b = 11'($urandom_range(0, a));        // reversed or empty
            3:       b = 11'(LEAF_COUNT);
            default: b = 11'(a + $urandom_range(1, 80));
        endcase
        if ($urandom_range(0, 9) < 4) send_request(OP_WRITE, a, b, pick_value());
        else                          send_request(OP_QUERY, a, b, $urandom);
    endtask

    initial begin
        int sent;
        int hot_lo;
        int burst;
        int wait_cycles;
        board = new();
        board.clear_store();
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = OP_QUERY;
        i_first_index = '0;
        i_end_index   = '0;
        i_new_value   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset contents, extremes, clamping, empty ranges
        send_request(OP_QUERY, 10'd0, 11'd1024, 32'h0);
        send_request(OP_QUERY, 10'd0, 11'd2047, 32'hffff_ffff);
        send_request(OP_WRITE, 10'd0, 11'd0, 32'h7fff_ffff);
        send_request(OP_WRITE, 10'd1023, 11'd2047, 32'h8000_0000);
        send_request(OP_WRITE, 10'd512, 11'h555, 32'h0000_0005);
        send_request(OP_WRITE, 10'd3, 11'h2aa, 32'hffff_fffe);
        send_request(OP_QUERY, 10'd0, 11'd1, 32'h0);
        send_request(OP_QUERY, 10'd1, 11'd1024, 32'h0);
        send_request(OP_QUERY, 10'd1023, 11'd1024, 32'h0);
        send_request(OP_QUERY, 10'd5, 11'd5, 32'h0);
        send_request(OP_QUERY, 10'd600, 11'd3, 32'h0);
        send_request(OP_QUERY, 10'd1023, 11'd0, 32'h0);
        send_request(OP_WRITE, 10'd1023, 11'd0, 32'h1234_5678);
        send_request(OP_QUERY, 10'd2, 11'd1500, 32'h0);
        send_request(OP_QUERY, 10'd513, 11'd1023, 32'h0);
        send_request(OP_WRITE, 10'd0, 11'd0, 32'h8000_0000);
        send_request(OP_QUERY, 10'd0, 11'd4, 32'h0);
        send_request(OP_QUERY, 10'd1, 11'd3, 32'h0);
        send_request(OP_QUERY, 10'd255, 11'd769, 32'h0);
        drop_start();

        // random bursts, mixed with stretches of back-to-back requests
        sent = 0;
        while (sent < N_RANDOM) begin
            hot_lo = $urandom_range(0, 1023);
            burst  = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                random_request(hot_lo);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end
        end
        start <= 1'b0;

        // drain, then let any trailing write finish
        while (board.pending_max.size() != 0) @(negedge i_clk);
        wait_cycles = 100;
        repeat (wait_cycles) @(negedge i_clk);

        if (board.mismatches == 0 && board.unexpected == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // generous watchdog: room for the clearing pass plus about 1600 requests
    initial begin
        #(2_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
